### src/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic [1:0]  message_kind;
        logic [15:0] byte_offset;
        logic        first_of_message;
        logic        last_of_message;
    } out_item_t;

    typedef struct packed {
        logic      emit;
        out_item_t item;
    } emit_t;

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_RESYNC = 1'b1;

    localparam logic [1:0] KIND_ENTER   = 2'd0;
    localparam logic [1:0] KIND_REPLACE = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [7:0] CHAR_ENTER   = 8'h4F;
    localparam logic [7:0] CHAR_REPLACE = 8'h55;
    localparam logic [7:0] CHAR_CANCEL  = 8'h58;

    function automatic logic [1:0] classify_kind(input logic [7:0] b);
        logic [1:0] k;
        case (b)
            CHAR_ENTER:   k = KIND_ENTER;
            CHAR_REPLACE: k = KIND_REPLACE;
            CHAR_CANCEL:  k = KIND_CANCEL;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

### src/lpd_in_reg.sv
// Input register stage holding one accepted item.
module lpd_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  lpd_pkg::in_item_t item,
    input  logic              take,
    output logic              stage_valid,
    output lpd_pkg::in_item_t stage_item
);

    logic              valid_reg;
    logic              valid_next;
    lpd_pkg::in_item_t item_reg;

    assign item_ready  = !valid_reg || take;
    assign valid_next  = item_ready ? item_valid : valid_reg;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

### src/lpd_frame_ctrl.sv
// Framing state and per-item result logic.
module lpd_frame_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stage_valid,
    input  lpd_pkg::in_item_t stage_item,
    input  logic              out_space,
    output logic              take,
    output lpd_pkg::emit_t    emit
);

    localparam logic [1:0] PH_LEN_HIGH = 2'd0;
    localparam logic [1:0] PH_LEN_LOW  = 2'd1;
    localparam logic [1:0] PH_BODY     = 2'd2;
    localparam logic [1:0] PH_UNUSED   = 2'd3;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [7:0]  length_high_reg;
    logic [7:0]  length_high_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [15:0] body_position_reg;
    logic [15:0] body_position_next;
    logic [1:0]  current_kind_reg;
    logic [1:0]  current_kind_next;

    logic        is_data;
    logic        in_body;
    logic        emit_want;
    logic        first;
    logic        last;
    logic [1:0]  kind;
    logic [15:0] len;

    assign is_data   = stage_item.command == lpd_pkg::CMD_DATA;
    assign in_body   = (phase_reg == PH_BODY) && (bytes_left_reg != 16'd0);
    assign emit_want = stage_valid && is_data && in_body;
    assign take      = stage_valid && (!emit_want || out_space);
    assign first     = body_position_reg == 16'd0;
    assign last      = bytes_left_reg == 16'd1;
    assign kind      = first ? lpd_pkg::classify_kind(stage_item.byte_value)
                             : current_kind_reg;
    assign len       = {length_high_reg, stage_item.byte_value};

    always_comb
    begin
        emit.emit                  = emit_want && out_space;
        emit.item.body_byte        = stage_item.byte_value;
        emit.item.message_kind     = kind;
        emit.item.byte_offset      = body_position_reg;
        emit.item.first_of_message = first;
        emit.item.last_of_message  = last;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        length_high_next   = length_high_reg;
        bytes_left_next    = bytes_left_reg;
        body_position_next = body_position_reg;
        current_kind_next  = current_kind_reg;
        if (take)
        begin
            if (!is_data)
            begin
                phase_next         = PH_LEN_HIGH;
                length_high_next   = 8'd0;
                bytes_left_next    = 16'd0;
                body_position_next = 16'd0;
                current_kind_next  = lpd_pkg::KIND_ENTER;
            end
            else if (phase_reg == PH_LEN_LOW)
            begin
                if (len == 16'd0)
                begin
                    phase_next = PH_LEN_HIGH;
                end
                else
                begin
                    bytes_left_next    = len;
                    body_position_next = 16'd0;
                    phase_next         = PH_BODY;
                end
            end
            else if (!in_body)
            begin
                length_high_next = stage_item.byte_value;
                phase_next       = PH_LEN_LOW;
            end
            else
            begin
                current_kind_next = kind;
                bytes_left_next   = bytes_left_reg - 16'd1;
                if (last)
                begin
                    phase_next         = PH_LEN_HIGH;
                    body_position_next = 16'd0;
                end
                else
                begin
                    body_position_next = body_position_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN_HIGH;
            length_high_reg   <= 8'd0;
            bytes_left_reg    <= 16'd0;
            body_position_reg <= 16'd0;
            current_kind_reg  <= lpd_pkg::KIND_ENTER;
        end
        else
        begin
            phase_reg         <= phase_next;
            length_high_reg   <= length_high_next;
            bytes_left_reg    <= bytes_left_next;
            body_position_reg <= body_position_next;
            current_kind_reg  <= current_kind_next;
        end
    end

    a_phase_used: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_UNUSED)
        else $error("unused phase entered");

    a_body_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (bytes_left_reg != 16'd0))
        else $error("body phase with no bytes left");

    a_header_position: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> (body_position_reg == 16'd0))
        else $error("body position not cleared outside body");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.emit && emit.item.last_of_message) |=> (phase_reg == PH_LEN_HIGH))
        else $error("message not closed after last byte");

endmodule

### src/lpd_out_reg.sv
// Result register with valid/ready handshake.
module lpd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  lpd_pkg::emit_t     emit,
    output logic               out_space,
    output logic               result_valid,
    input  logic               result_ready,
    output lpd_pkg::out_item_t result
);

    logic               valid_reg;
    logic               valid_next;
    lpd_pkg::out_item_t item_reg;

    assign out_space    = !valid_reg || result_ready;
    assign valid_next   = out_space ? emit.emit : valid_reg;
    assign result_valid = valid_reg;
    assign result       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.emit)
        begin
            item_reg <= emit.item;
        end
    end

endmodule

### src/length_prefixed_deframer.sv
// Top level of the 16-bit big-endian length-prefixed deframer.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------
//  item    | item_valid / item_ready     | command, byte_value
//  result  | result_valid / result_ready | body_byte, message_kind,
//          |                             | byte_offset, first/last marks
//
// One item per cycle while no result stalls; the result register loads as a body
// item leaves the input register, so its result is valid after both registers.
// Header bytes, zero-length headers and resync commands give no result.
// Reset returns the framer to awaiting a length high byte.
// A stalled result holds the next body item in the input register, which then
// drops item_ready; header and command items still pass while a result waits.
module length_prefixed_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  lpd_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output lpd_pkg::out_item_t result
);

    logic              stage_valid;
    lpd_pkg::in_item_t stage_item;
    logic              take;
    logic              out_space;
    lpd_pkg::emit_t    emit;

    lpd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    lpd_frame_ctrl u_frame_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .out_space   (out_space),
        .take        (take),
        .emit        (emit)
    );

    lpd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .out_space    (out_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### tb/length_prefixed_deframer_checker.sv
// Checker for the length-prefixed deframer: predicts body-byte results from accepted items.
module length_prefixed_deframer_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  lpd_pkg::in_item_t  item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  lpd_pkg::out_item_t result,
    output int                 fail_count,
    output int                 pending,
    output int                 bytes_checked
);

    localparam int REPORT_LIMIT = 100;

    typedef enum logic [1:0] {
        AWAIT_LEN_HIGH = 2'd0,
        AWAIT_LEN_LOW  = 2'd1,
        IN_BODY        = 2'd2,
        UNUSED_PHASE   = 2'd3
    } frame_phase_t;

    frame_phase_t       phase;
    logic [7:0]         len_high;
    logic [15:0]        remaining;
    logic [15:0]        offset;
    logic [1:0]         kind;
    lpd_pkg::out_item_t expected_bytes[$];
    int                 reported;

    function automatic logic [1:0] kind_of_type_byte(input logic [7:0] b);
        if (b == lpd_pkg::CHAR_ENTER)
            return lpd_pkg::KIND_ENTER;
        else if (b == lpd_pkg::CHAR_REPLACE)
            return lpd_pkg::KIND_REPLACE;
        else if (b == lpd_pkg::CHAR_CANCEL)
            return lpd_pkg::KIND_CANCEL;
        return lpd_pkg::KIND_UNKNOWN;
    endfunction

    task automatic clear_framer();
        phase     = AWAIT_LEN_HIGH;
        len_high  = '0;
        remaining = '0;
        offset    = '0;
        kind      = lpd_pkg::KIND_ENTER;
    endtask

    task automatic advance_framer(input lpd_pkg::in_item_t it);
        lpd_pkg::out_item_t body;
        logic [15:0]        length;
        if (it.command == lpd_pkg::CMD_RESYNC)
        begin
            clear_framer();
        end
        else if (phase == AWAIT_LEN_LOW)
        begin
            length = {len_high, it.byte_value};
            if (length == 16'd0)
            begin
                phase = AWAIT_LEN_HIGH;
            end
            else
            begin
                remaining = length;
                offset    = '0;
                phase     = IN_BODY;
            end
        end
        else if (phase != IN_BODY || remaining == 16'd0)
        begin
            len_high = it.byte_value;
            phase    = AWAIT_LEN_LOW;
        end
        else
        begin
            if (offset == 16'd0)
                kind = kind_of_type_byte(it.byte_value);
            body.body_byte        = it.byte_value;
            body.message_kind     = kind;
            body.byte_offset      = offset;
            body.first_of_message = (offset == 16'd0);
            body.last_of_message  = (remaining == 16'd1);
            expected_bytes.insert(expected_bytes.size(), body);
            remaining = remaining - 16'd1;
            offset    = offset + 16'd1;
            if (remaining == 16'd0)
            begin
                phase  = AWAIT_LEN_HIGH;
                offset = '0;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (reported < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
            reported++;
        end
    endtask

    task automatic compare_result(input lpd_pkg::out_item_t got);
        lpd_pkg::out_item_t want;
        if (expected_bytes.size() == 0)
        begin
            fail_count++;
            if (reported < REPORT_LIMIT)
                $display("%0t: unexpected result, expected none, got byte 0x%0h offset %0d",
                         $time, got.body_byte, got.byte_offset);
            reported++;
        end
        else
        begin
            want = expected_bytes.pop_front();
            check_field("body_byte", 16'(want.body_byte), 16'(got.body_byte));
            check_field("message_kind", 16'(want.message_kind),
                        16'(got.message_kind));
            check_field("byte_offset", want.byte_offset, got.byte_offset);
            check_field("first_of_message", 16'(want.first_of_message),
                        16'(got.first_of_message));
            check_field("last_of_message", 16'(want.last_of_message),
                        16'(got.last_of_message));
            bytes_checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_framer();
            expected_bytes.delete();
            fail_count    = 0;
            bytes_checked = 0;
            reported      = 0;
            pending       = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                advance_framer(item);
            if (result_valid && result_ready)
                compare_result(result);
            pending = expected_bytes.size();
        end
    end

endmodule

### tb/length_prefixed_deframer_tb.sv
// Testbench top for the length-prefixed deframer: stimulus, flow control and verdict.
module length_prefixed_deframer_tb;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 420;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    lpd_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_ready;
    lpd_pkg::out_item_t result;

    int fail_count;
    int pending;
    int bytes_checked;
    int items_sent        = 0;
    int messages_sent     = 0;
    int resyncs_sent      = 0;
    int burst_left        = 0;
    int idle_cycles       = 0;
    int hold_off_requests = 0;

    length_prefixed_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    length_prefixed_deframer_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("length_prefixed_deframer test failed");
            $finish;
        end
    end

    // Receiver: stall pattern of its own, plus a long hold-off on request.
    initial
    begin
        int seg_left;
        int mode;
        int stall;
        int hold_off_served;
        result_ready    = 1'b0;
        seg_left        = 0;
        mode            = 0;
        hold_off_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_requests > hold_off_served)
            begin
                hold_off_served++;
                result_ready <= 1'b0;
                for (stall = 0; stall < HOLD_OFF_CYCLES; stall++)
                    @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ~result_ready;
                endcase
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        lpd_pkg::in_item_t it;
        int                gap;
        it.command    = cmd;
        it.byte_value = b;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(lpd_pkg::CMD_DATA, b);
    endtask

    task automatic send_resync();
        send_item(lpd_pkg::CMD_RESYNC, 8'($urandom_range(0, 255)));
        resyncs_sent++;
    endtask

    // Header, then the body; a cut point inside the body ends it with a resync.
    task automatic send_message(input logic [15:0] len, input logic [7:0] type_byte,
                                input int cut_after);
        int n;
        int i;
        n = (cut_after >= 0 && cut_after < len) ? cut_after : len;
        send_data(len[15:8]);
        send_data(len[7:0]);
        for (i = 0; i < n; i++)
            send_data((i == 0) ? type_byte : 8'($urandom_range(0, 255)));
        if (n < len)
            send_resync();
        else
            messages_sent++;
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] random_type_byte();
        case ($urandom_range(0, 3))
            0:       return lpd_pkg::CHAR_ENTER;
            1:       return lpd_pkg::CHAR_REPLACE;
            2:       return lpd_pkg::CHAR_CANCEL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] random_length();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(9, 40));
        return 16'($urandom_range(1, 8));
    endfunction

    initial
    begin
        int directed_end;
        int pick;
        bit hold_done;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        hold_done  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_message(16'd0, 8'h00, -1);
        send_message(16'd1, lpd_pkg::CHAR_ENTER, -1);
        send_message(16'd2, lpd_pkg::CHAR_REPLACE, -1);
        send_message(16'd2, lpd_pkg::CHAR_CANCEL, -1);
        send_message(16'd1, 8'h00, -1);
        send_item(lpd_pkg::CMD_RESYNC, 8'hFF);
        resyncs_sent++;
        send_data(8'h12);
        send_resync();
        send_message(16'd4, 8'hFF, 2);
        send_message(16'd1, lpd_pkg::CHAR_ENTER, -1);
        wait_for_drain();
        directed_end = items_sent;

        while (items_sent < directed_end + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (!hold_done && items_sent > directed_end + 300)
            begin
                hold_off_requests++;
                send_message(16'd48, random_type_byte(), -1);
                wait_for_drain();
                hold_done = 1'b1;
            end
            else if (pick < 68)
            begin
                send_message(random_length(), random_type_byte(), -1);
            end
            else if (pick < 76)
            begin
                send_message(16'd0, 8'h00, -1);
            end
            else if (pick < 84)
            begin
                send_message(16'($urandom_range(1, 65535)), random_type_byte(),
                             $urandom_range(0, 4));
            end
            else if (pick < 88)
            begin
                send_data(8'($urandom_range(0, 255)));
                send_resync();
            end
            else if (pick < 93)
            begin
                send_resync();
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_data(8'($urandom_range(0, 255)));
                send_resync();
            end
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
        end

        send_message(16'd300, random_type_byte(), -1);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items: %0d whole messages, %0d resyncs, %0d body bytes checked.",
                 items_sent, messages_sent, resyncs_sent, bytes_checked);
        $display("Included zero-length and truncated frames, noise, a 300-byte body %s",
                 "and a long receiver hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("length_prefixed_deframer test passed");
        else
            $display("length_prefixed_deframer test failed");
        $finish;
    end

endmodule

### filelist.f
src/lpd_pkg.sv
src/lpd_in_reg.sv
src/lpd_frame_ctrl.sv
src/lpd_out_reg.sv
src/length_prefixed_deframer.sv
tb/length_prefixed_deframer_checker.sv
tb/length_prefixed_deframer_tb.sv
